// ===== hw/rtl/lie_pkg.sv =====
package lie_pkg;

	localparam int unsigned POS_W    = 9;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned LINE_MAX = 256;

	localparam logic [POS_W-1:0] CAP_RESET = 9'd80;
	localparam logic [POS_W-1:0] CAP_MAX   = POS_W'(LINE_MAX);

	localparam logic [CHAR_W-1:0] KEY_NONE  = 8'd0;
	localparam logic [CHAR_W-1:0] KEY_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] KEY_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] KEY_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] KEY_SPACE = 8'd32;

	typedef enum logic [1:0] {
		RUN_CHAR = 2'd0,
		RUN_BS   = 2'd1,
		RUN_EOL  = 2'd2
	} run_kind_t;

	// one decoded key: everything the emitter needs to produce its beats
	typedef struct packed {
		run_kind_t         kind;
		logic [CHAR_W-1:0] code;
		logic [POS_W-1:0]  pos;
		logic              full;
	} run_t;

	typedef struct packed {
		logic load;
		run_t run;
	} emit_ctl_t;

endpackage

// ===== hw/rtl/lie_key_if.sv =====
interface lie_key_if;
	import lie_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);

endinterface

// ===== hw/rtl/lie_res_if.sv =====
interface lie_res_if;
	import lie_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] echo_char;
	logic              store_valid;
	logic [7:0]        store_index;
	logic [CHAR_W-1:0] store_char;
	logic              line_done;
	logic [POS_W-1:0]  line_length;
	logic              last_of_run;

	modport source (
		output valid, output echo_char, output store_valid, output store_index,
		output store_char, output line_done, output line_length, output last_of_run,
		input  ready
	);
	modport sink (
		input  valid, input echo_char, input store_valid, input store_index,
		input  store_char, input line_done, input line_length, input last_of_run,
		output ready
	);

endinterface

// ===== hw/rtl/line_input_editor.sv =====
// An accepted key waits in the input register, then loads the emitter, which
// shows its first echo beat: one beat per printable key, two for CR/LF, three
// for backspace, one beat per cycle while results.ready is high. Keys with no
// beats skip the emitter; the next key is taken while beats still drain.
// Reset (arst_n low) empties both stages, sets position 0 and capacity 80.
module line_input_editor import lie_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lie_key_if.sink          keys,
	lie_res_if.source        results,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata
);

	logic              s1_valid_q;
	logic [CHAR_W-1:0] key_s1;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  cap_q;

	logic              has_run;
	run_t              run;
	logic [POS_W-1:0]  next_pos;
	logic              emit_free;
	logic              s1_take;
	emit_ctl_t         emit_ctl;

	lie_decode u_decode (
		.key_code (key_s1),
		.pos      (pos_q),
		.capacity (cap_q),
		.has_run  (has_run),
		.run      (run),
		.next_pos (next_pos)
	);

	// keys without any beat leave the input stage without waiting on the emitter
	assign s1_take       = s1_valid_q && (!has_run || emit_free);
	assign emit_ctl.load = s1_take && has_run;
	assign emit_ctl.run  = run;
	assign keys.ready    = !s1_valid_q || s1_take;

	lie_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (emit_ctl),
		.free   (emit_free),
		.res    (results)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			pos_q      <= '0;
			cap_q      <= CAP_RESET;
		end else begin
			if (keys.valid && keys.ready) begin
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_take) begin
				pos_q <= next_pos;
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			key_s1 <= keys.key_code;
		end
	end

`ifndef ASSERT_OFF
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.line_done |-> results.last_of_run)
		else $error("line_done on a beat that is not the last of its run");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && results.last_of_run && !emit_ctl.load
		|=> !results.valid)
		else $error("emitter kept sending after the last beat of a run");

	a_key_held: assert property (@(posedge clk) disable iff (!arst_n)
		keys.valid && keys.ready |=> s1_valid_q)
		else $error("accepted key lost from the input stage");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take |=> pos_q < CAP_MAX)
		else $error("line position reached the line maximum");
`endif

endmodule

// ===== hw/rtl/lie_decode.sv =====
module lie_decode import lie_pkg::*; (
	input  logic [CHAR_W-1:0] key_code,
	input  logic [POS_W-1:0]  pos,
	input  logic [POS_W-1:0]  capacity,
	output logic              has_run,
	output run_t              run,
	output logic [POS_W-1:0]  next_pos
);

	logic [POS_W-1:0] cap_eff;
	logic [POS_W:0]   pos_inc;
	logic             full;

	always_comb begin
		if (capacity == '0) begin
			cap_eff = POS_W'(1);
		end else if (capacity > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = capacity;
		end
	end

	assign pos_inc = {1'b0, pos} + (POS_W+1)'(1);
	assign full    = pos_inc >= {1'b0, cap_eff};

	always_comb begin
		has_run   = 1'b0;
		next_pos  = pos;
		run.kind  = RUN_CHAR;
		run.code  = key_code;
		run.pos   = pos;
		run.full  = full;
		case (key_code)
			KEY_NONE: begin
				has_run = 1'b0;
			end
			KEY_BS: begin
				// backspace on an empty line is swallowed
				if (pos != '0) begin
					has_run  = 1'b1;
					run.kind = RUN_BS;
					next_pos = pos - POS_W'(1);
				end
			end
			KEY_LF, KEY_CR: begin
				has_run  = 1'b1;
				run.kind = RUN_EOL;
				next_pos = '0;
			end
			default: begin
				has_run  = 1'b1;
				run.kind = RUN_CHAR;
				next_pos = full ? '0 : pos_inc[POS_W-1:0];
			end
		endcase
	end

endmodule

// ===== hw/rtl/lie_emit.sv =====
module lie_emit import lie_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  emit_ctl_t  ctl,
	output logic       free,
	lie_res_if.source  res
);

	logic       busy_q;
	run_t       run_q;
	logic [1:0] beat_q;
	logic       fire;
	logic       last;

	always_comb begin
		res.echo_char   = '0;
		res.store_valid = 1'b0;
		res.store_index = '0;
		res.store_char  = '0;
		res.line_done   = 1'b0;
		res.line_length = '0;
		last            = 1'b1;
		case (run_q.kind)
			RUN_BS: begin
				res.echo_char = (beat_q == 2'd1) ? KEY_SPACE : KEY_BS;
				last          = beat_q == 2'd2;
			end
			RUN_EOL: begin
				if (beat_q == 2'd0) begin
					res.echo_char   = KEY_CR;
					res.store_valid = 1'b1;
					res.store_index = run_q.pos[7:0];
					last            = 1'b0;
				end else begin
					res.echo_char   = KEY_LF;
					res.line_done   = 1'b1;
					res.line_length = run_q.pos;
				end
			end
			RUN_CHAR: begin
				res.echo_char   = run_q.code;
				res.store_valid = 1'b1;
				res.store_index = run_q.pos[7:0];
				res.store_char  = run_q.code;
				res.line_done   = run_q.full;
				res.line_length = run_q.full ? run_q.pos + POS_W'(1) : '0;
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	assign res.valid       = busy_q;
	assign res.last_of_run = last;
	assign fire            = busy_q && res.ready;
	assign free            = !busy_q || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			run_q <= ctl.run;
		end
	end

endmodule
